### hdl/wsg_pkg.sv
// wsg_pkg: shared types, codes and the sine table builder for the waveform sample generator
// no dependencies; imported by wsg_sine_rom and waveform_sample_generator_unit
package wsg_pkg;

  typedef enum logic [2:0] {
    WAVE_SINE,
    WAVE_TRIANGLE,
    WAVE_SQUARE,
    WAVE_SAWTOOTH,
    WAVE_PULSE,
    WAVE_MAX,
    WAVE_ZERO,
    WAVE_MIN
  } wave_t;

  typedef enum logic [1:0] {
    REG_WAVE,
    REG_STEP,
    REG_DUTY,
    REG_AMP
  } reg_index_t;

  localparam int STEP_W   = 32;
  localparam int DUTY_W   = 24;
  localparam int AMP_W    = 15;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 32;
  localparam int ROM_W    = 31;   // q1.30, holds 0 .. 2^30
  localparam int UNIT_W   = 33;   // signed q1.31 unit waveform, -2^31 .. 2^31

  localparam logic signed [UNIT_W-1:0] UNIT_POS = 33'sh0_8000_0000;
  localparam logic signed [UNIT_W-1:0] UNIT_NEG = 33'sh1_8000_0000;

  localparam logic [AMP_W-1:0]    AMP_RESET  = 15'h7fff;
  localparam logic [SAMPLE_W-2:0] SAMPLE_MAX = 15'h7fff;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned TAYLOR_DIV [1:12] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

  // sin(pi/2 * k / 2^tb) in q1.30 by a fixed-point taylor series, clamped to [0, 1]
  function automatic logic [ROM_W-1:0] sine_entry(int k, int tb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x = (HALF_PI_Q30 * longint'(k) + (longint'(1) << (tb - 1))) >> tb;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    return ROM_W'(sum);
  endfunction

endpackage

### hdl/wsg_sine_rom.sv
// wsg_sine_rom: quarter-wave sine table, 2^TABLE_BITS+1 entries, two registered read ports
// depends on wsg_pkg for the table builder
module wsg_sine_rom import wsg_pkg::*; #(
  parameter int TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [TABLE_BITS:0]   addr_a,
  input  logic [TABLE_BITS:0]   addr_b,
  output logic [ROM_W-1:0]      data_a,
  output logic [ROM_W-1:0]      data_b
);

  localparam int DEPTH = (1 << TABLE_BITS) + 1;

  logic [ROM_W-1:0] rom [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    assign rom[k] = sine_entry(k, TABLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= rom[addr_a];
      data_b <= rom[addr_b];
    end
  end

endmodule

### hdl/waveform_sample_generator_unit.sv
// waveform_sample_generator_unit: time index in, amplitude-scaled waveform sample out
// depends on wsg_pkg and wsg_sine_rom
//
//   channel   signals                                   payload
//   time      time_valid, time_stall                    time_index
//   sample    sample_valid, sample_stall                sample
//   config    cfg_valid, cfg_ready                      cfg_index, cfg_data
//
// one request per clock while time_stall is low; on its way out a sample passes
// the phase multiplier, the registered sine table read, the interpolation
// multiplier and the amplitude multiplier, each followed by a register.
// rst is synchronous; it empties the pipeline and restores the register defaults.
// each of the seven stages holds while the one after it is full and held, so a
// stalled sample stays put and bubbles close up behind it.
module waveform_sample_generator_unit import wsg_pkg::*; #(
  parameter int TIME_BITS       = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        time_valid,
  output logic                        time_stall,
  input  logic [TIME_BITS-1:0]        time_index,
  output logic                        sample_valid,
  input  logic                        sample_stall,
  output logic signed [SAMPLE_W-1:0]  sample,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  localparam int PW     = TIME_BITS + STEP_W;
  localparam int CW     = (TIME_BITS > DUTY_W) ? TIME_BITS : DUTY_W;
  localparam int FB     = 30 - SINE_TABLE_BITS;
  localparam int DW     = ROM_W + FB;
  localparam int PROD_W = UNIT_W + AMP_W + 1;
  localparam int NSTAGE = 7;

  localparam logic [SINE_TABLE_BITS:0] TABLE_TOP = {1'b1, {SINE_TABLE_BITS{1'b0}}};
  localparam logic [DW-1:0]            INTERP_HALF = DW'(1) << (FB - 1);
  localparam logic [PW-1:0]            ONE_CYCLE = PW'(64'h1_0000_0000);

  // configuration registers
  wave_t              waveform_select;
  logic [STEP_W-1:0]  cycle_step;
  logic [DUTY_W-1:0]  duty_ticks;
  logic [AMP_W-1:0]   amplitude;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform_select <= WAVE_SINE;
      cycle_step      <= '0;
      duty_ticks      <= '0;
      amplitude       <= AMP_RESET;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_WAVE: waveform_select <= wave_t'(cfg_data[2:0]);
        REG_STEP: cycle_step      <= cfg_data[STEP_W-1:0];
        REG_DUTY: duty_ticks      <= cfg_data[DUTY_W-1:0];
        REG_AMP:  amplitude       <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // stage flow control
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] rdy;

  always_comb begin
    rdy[NSTAGE-1] = !vld[NSTAGE-1] || !sample_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign time_stall   = !rdy[0];
  assign sample_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= time_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 0: request capture
  logic [TIME_BITS-1:0] t0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      t0 <= time_index;
    end
  end

  // stage 1: phase product and duty compare
  logic [PW-1:0] p1;
  logic          sq1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p1  <= PW'(t0) * PW'(cycle_step);
      sq1 <= CW'(t0) < CW'(duty_ticks);
    end
  end

  // stage 1 logic: table address and the waveforms that need no table
  logic [31:0]                 f1;
  logic [30:0]                 g1;
  logic [30:0]                 u_sine;
  logic [30:0]                 u_pulse;
  logic [30:0]                 u1;
  logic [SINE_TABLE_BITS:0]    addr_a;
  logic [SINE_TABLE_BITS:0]    addr_b;
  logic signed [34:0]          tri_v;
  logic signed [34:0]          saw1;
  logic signed [UNIT_W-1:0]    d1;
  logic [31:0]                 pulse_wrap;

  always_comb begin
    f1 = p1[31:0];
    g1 = f1[31:1];
    u_sine = f1[30] ? (31'h4000_0000 - {1'b0, f1[29:0]}) : {1'b0, f1[29:0]};
    pulse_wrap = 32'h8000_0000 - {1'b0, g1};
    u_pulse = g1[30] ? pulse_wrap[30:0] : g1;
    u1 = (waveform_select == WAVE_PULSE) ? u_pulse : u_sine;
    addr_a = u1[30:FB];
    addr_b = (addr_a == TABLE_TOP) ? addr_a : addr_a + (SINE_TABLE_BITS + 1)'(1);

    // triangle in q.31: rising, falling, rising again
    case (f1[31:30])
      2'd0:    tri_v = $signed({3'b000, f1}) <<< 1;
      2'd3:    tri_v = ($signed({3'b000, f1}) - 35'sh1_0000_0000) <<< 1;
      default: tri_v = (35'sh0_8000_0000 - $signed({3'b000, f1})) <<< 1;
    endcase

    saw1 = 35'sh0_8000_0000 - $signed({2'b00, p1[32:0]});

    case (waveform_select)
      WAVE_TRIANGLE: d1 = tri_v[UNIT_W-1:0];
      WAVE_SQUARE:   d1 = sq1 ? UNIT_POS : UNIT_NEG;
      WAVE_SAWTOOTH: d1 = (p1 > ONE_CYCLE) ? UNIT_NEG : saw1[UNIT_W-1:0];
      WAVE_MAX:      d1 = UNIT_POS;
      WAVE_MIN:      d1 = UNIT_NEG;
      default:       d1 = '0;
    endcase
  end

  // stage 2: table read
  logic [ROM_W-1:0]         rom_a;
  logic [ROM_W-1:0]         rom_b;
  logic [FB-1:0]            fr2;
  logic                     neg2;
  logic signed [UNIT_W-1:0] d2;

  wsg_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (rdy[2]),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .data_a (rom_a),
    .data_b (rom_b)
  );

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      fr2  <= u1[FB-1:0];
      neg2 <= f1[31];
      d2   <= d1;
    end
  end

  // stage 3: interpolation product
  logic [ROM_W-1:0]         diff2;
  logic [DW-1:0]            prod3;
  logic [ROM_W-1:0]         a3;
  logic                     neg3;
  logic signed [UNIT_W-1:0] d3;

  assign diff2 = (rom_b < rom_a) ? '0 : rom_b - rom_a;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      prod3 <= DW'(diff2) * DW'(fr2);
      a3    <= rom_a;
      neg3  <= neg2;
      d3    <= d2;
    end
  end

  // stage 4: interpolated sine, shaped to the selected unit value
  logic [DW-1:0]            prod_rnd;
  logic [31:0]              qs;
  logic signed [34:0]       qs_s;
  logic signed [34:0]       sine_v;
  logic signed [34:0]       pulse_v;
  logic signed [UNIT_W-1:0] unit3;
  logic signed [UNIT_W-1:0] u4;

  always_comb begin
    prod_rnd = prod3 + INTERP_HALF;
    qs = {1'b0, a3} + {1'b0, prod_rnd[FB +: ROM_W]};
    qs_s = $signed({3'b000, qs});
    sine_v = neg3 ? -(qs_s <<< 1) : (qs_s <<< 1);
    pulse_v = (qs_s <<< 2) - 35'sh0_8000_0000;
    case (waveform_select)
      WAVE_SINE:  unit3 = sine_v[UNIT_W-1:0];
      WAVE_PULSE: unit3 = pulse_v[UNIT_W-1:0];
      default:    unit3 = d3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      u4 <= unit3;
    end
  end

  // stage 5: amplitude scaling
  logic signed [AMP_W:0]    amp_s;
  logic signed [PROD_W-1:0] prod5;

  assign amp_s = $signed({1'b0, amplitude});

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      prod5 <= PROD_W'(amp_s) * PROD_W'(u4);
    end
  end

  // stage 6: round half away from zero, saturate
  logic [PROD_W-1:0]    mag;
  logic [PROD_W-1:0]    mag_rnd;
  logic [PROD_W-32:0]   rmag;
  logic [SAMPLE_W-2:0]  sat;
  logic [SAMPLE_W-1:0]  sample_next;

  always_comb begin
    mag = prod5[PROD_W-1] ? PROD_W'(-prod5) : PROD_W'(prod5);
    mag_rnd = mag + (PROD_W'(1) << 30);
    rmag = mag_rnd[PROD_W-1:31];
    sat = (rmag > (PROD_W-31)'(SAMPLE_MAX)) ? SAMPLE_MAX : rmag[SAMPLE_W-2:0];
    sample_next = prod5[PROD_W-1] ? -{1'b0, sat} : {1'b0, sat};
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      sample <= $signed(sample_next);
    end
  end

endmodule
